// ----- rtl/dlfb_pkg.sv -----
// Package for the dense layer core: action, result-kind and config-index codes, payload structs, widths.
// No dependencies.
package dlfb_pkg;
    localparam int VAL_W = 16;
    localparam logic [2:0] ACT_LOAD_W  = 3'd0;
    localparam logic [2:0] ACT_LOAD_B  = 3'd1;
    localparam logic [2:0] ACT_FWD     = 3'd2;
    localparam logic [2:0] ACT_OGRAD   = 3'd3;
    localparam logic [2:0] ACT_BWD     = 3'd4;
    localparam logic [2:0] ACT_CLEAR   = 3'd5;
    localparam logic [2:0] ACT_RD_WG   = 3'd6;
    localparam logic [2:0] ACT_RD_BG   = 3'd7;
    localparam logic [1:0] KIND_FWD = 2'd0;
    localparam logic [1:0] KIND_IG  = 2'd1;
    localparam logic [1:0] KIND_WG  = 2'd2;
    localparam logic [1:0] KIND_BG  = 2'd3;
    localparam logic [1:0] CFG_NIN   = 2'd0;
    localparam logic [1:0] CFG_NOUT  = 2'd1;
    localparam logic [1:0] CFG_BIAS  = 2'd2;
    localparam logic [1:0] CFG_BATCH = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  row;
        logic [5:0]  col;
        logic signed [15:0] value;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  index;
        logic signed [15:0] result;
        logic        final_res;
    } t_out;
endpackage

// ----- rtl/dlfb_if.sv -----
// Valid/ready channel interface carrying one payload of type T.
// Has no dependencies; the payload type comes in as a parameter.
interface dlfb_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/dense_layer_forward_backward_core.sv -----
// Dense layer core: Q8.8 forward/backward pass through one shared 16x16 MAC.
// Per transfer (n = active outputs): loads write one entry, output gradient also adds to its
// bias gradient sum with bias on, forward input walks n weights, forward last then emits n
// results, backward walks n weights and emits one, gradient reads emit n (48-step serial
// divide each), clear sweeps all gradient sums. Out-of-range rows or cols skip that work.
// Synchronous active-low reset on i_rst_n; a pass then zeros the sums, no transfer in.
module dense_layer_forward_backward_core
    import dlfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    dlfb_if.sink        in_ch,
    dlfb_if.source      out_ch
);
    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_EX = 4'd3,
        S_DIV = 4'd4, S_OUT = 4'd5, S_CLR = 4'd6, S_EMIT1 = 4'd7, S_WB = 4'd8;

    logic [3:0]  r_st;
    logic [6:0]  r_nin, r_nout;
    logic        r_bias;
    logic [10:0] r_batch;
    t_in         r_it;
    logic [5:0]  r_k;
    logic [11:0] r_clr;
    logic signed [39:0] r_s;
    logic [5:0]  r_dcnt;
    logic [47:0] r_q, r_rem;
    logic        r_neg;
    logic        r_ov;
    t_out        r_o;

    logic [15:0] m_w [0:4095];
    logic [15:0] m_b [0:63];
    logic [15:0] m_g [0:63];
    logic [39:0] m_acc [0:63];
    logic [47:0] m_wg [0:4095];
    logic [39:0] m_bg [0:63];
    logic [15:0] r_wd, r_bd, r_gd;
    logic [39:0] r_ad, r_bgd;
    logic [47:0] r_wgd;

    logic [6:0]  nin, nout;
    logic [10:0] batch;
    assign nin   = (r_nin == 0) ? 7'd1 : (r_nin > 7'd64 ? 7'd64 : r_nin);
    assign nout  = (r_nout == 0) ? 7'd1 : (r_nout > 7'd64 ? 7'd64 : r_nout);
    assign batch = (r_batch == 0) ? 11'd1 : (r_batch > 11'd1024 ? 11'd1024 : r_batch);

    logic row_ok, col_ok, lastk;
    assign row_ok = {1'b0, r_it.row} < nin;
    assign col_ok = {1'b0, r_it.col} < nout;
    assign lastk  = ({1'b0, r_k} == nout - 7'd1);

    function automatic logic signed [39:0] sat40(input logic signed [49:0] v);
        if (v > 50'sh7F_FFFF_FFFF) return 40'sh7F_FFFF_FFFF;
        if (v < -50'sh80_0000_0000) return -40'sh80_0000_0000;
        return v[39:0];
    endfunction
    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        if (v > 50'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (v < -50'sh8000_0000_0000) return -48'sh8000_0000_0000;
        return v[47:0];
    endfunction
    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sh7FFF) return 16'sh7FFF;
        if (v < -48'sh8000) return -16'sh8000;
        return v[15:0];
    endfunction

    // Shared multiplier: one 16x16 product per cycle.
    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] mul_p;
    always_comb begin
        mul_a = $signed(r_wd);
        mul_b = r_it.value;
        if (r_it.action == ACT_BWD) begin
            mul_a = (r_dcnt[0]) ? r_it.value : $signed(r_wd);
            mul_b = $signed(r_gd);
        end
    end
    assign mul_p = mul_a * mul_b;

    logic [11:0] addr;
    assign addr = {r_it.row, r_k};

    assign in_ch.ready = (r_st == S_IDLE);
    assign out_ch.valid = (r_st == S_OUT);
    assign out_ch.data  = r_o;

    logic signed [47:0] dsum;
    logic [47:0] dtry;
    assign dsum = (r_it.action == ACT_RD_WG) ? $signed(r_wgd) : 48'($signed(r_bgd));
    assign dtry = {r_rem[46:0], r_q[47]} - {37'd0, batch};

    // Forward output sum: accumulator plus bias scaled up by the fraction bits, or the accumulator alone with bias off
    logic signed [39:0] fsum;
    assign fsum = r_bias ? sat40($signed({{10{r_ad[39]}}, r_ad})
                                 + $signed({{26{r_bd[15]}}, r_bd, 8'd0}))
                         : $signed(r_ad);

    // Quotient sign fix for gradient reads.
    logic signed [47:0] qs;
    assign qs = r_neg ? -$signed({r_q[46:0], ~dtry[47]}) : $signed({r_q[46:0], ~dtry[47]});

    always_ff @(posedge i_clk) begin
        r_wd <= m_w[addr];
        r_bd <= m_b[r_k];
        r_gd <= m_g[r_k];
        r_ad <= m_acc[r_k];
        r_bgd <= m_bg[r_k];
        r_wgd <= m_wg[addr];
        if (!i_rst_n) begin
            r_st <= S_INIT; r_clr <= '0; r_nin <= 7'd64; r_nout <= 7'd64;
            r_bias <= 1'b1; r_batch <= 11'd1; r_k <= '0; r_dcnt <= '0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NIN:   r_nin <= i_cfg_data[6:0];
                    CFG_NOUT:  r_nout <= i_cfg_data[6:0];
                    CFG_BIAS:  r_bias <= i_cfg_data[0];
                    CFG_BATCH: r_batch <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_st)
                S_INIT, S_CLR: begin
                    // sweep gradient sums to zero, and the accumulators too after reset
                    m_wg[r_clr] <= '0;
                    if (r_clr[11:6] == 6'd0) begin
                        m_bg[r_clr[5:0]] <= '0;
                        if (r_st == S_INIT) m_acc[r_clr[5:0]] <= '0;
                    end
                    r_clr <= r_clr + 12'd1;
                    if (r_clr == 12'hFFF) r_st <= S_IDLE;
                end
                S_IDLE: if (in_ch.valid) begin
                    r_it <= in_ch.data; r_k <= '0; r_dcnt <= '0;
                    r_s <= '0; r_clr <= '0;
                    r_st <= (in_ch.data.action == ACT_CLEAR) ? S_CLR : S_RD;
                end
                S_RD: r_st <= S_EX;   // memory read data lands
                S_EX: begin
                    case (r_it.action)
                        ACT_LOAD_W: begin
                            if (row_ok && col_ok) m_w[{r_it.row, r_it.col}] <= r_it.value;
                            r_st <= S_IDLE;
                        end
                        ACT_LOAD_B: begin
                            if (col_ok) m_b[r_it.col] <= r_it.value;
                            r_st <= S_IDLE;
                        end
                        ACT_OGRAD: begin
                            if (col_ok) m_g[r_it.col] <= r_it.value;
                            if (col_ok && r_bias) begin
                                r_k <= r_it.col; r_st <= S_WB;
                            end else r_st <= S_IDLE;
                        end
                        ACT_FWD: begin
                            if (row_ok)
                                m_acc[r_k] <= sat40($signed({{10{r_ad[39]}}, r_ad})
                                    + 50'(mul_p));
                            // walk every output for an in-range row, then emit if this input closes the sample
                            if (row_ok && !lastk) begin
                                r_k <= r_k + 6'd1; r_st <= S_RD;
                            end else if (r_it.last) r_st <= S_EMIT1;
                            else r_st <= S_IDLE;
                        end
                        ACT_BWD: if (!row_ok) r_st <= S_IDLE;
                        else if (!r_dcnt[0]) begin
                            r_s <= sat40($signed({{10{r_s[39]}}, r_s}) + 50'(mul_p));
                            r_dcnt <= 6'd1; r_st <= S_EX;
                        end else begin
                            m_wg[addr] <= sat48($signed({{2{r_wgd[47]}}, r_wgd})
                                + 50'(mul_p));
                            r_dcnt <= '0;
                            if (lastk) r_st <= S_EMIT1;
                            else begin r_k <= r_k + 6'd1; r_st <= S_RD; end
                        end
                        ACT_RD_WG, ACT_RD_BG: begin
                            if (r_it.action == ACT_RD_WG && !row_ok) r_st <= S_IDLE;
                            else begin
                                r_neg <= dsum[47];
                                r_q <= dsum[47] ? 48'(-dsum) : dsum;
                                r_rem <= '0; r_dcnt <= '0; r_st <= S_DIV;
                            end
                        end
                        default: r_st <= S_IDLE;
                    endcase
                end
                S_WB: begin
                    // bias gradient read lands in the cycle after r_k takes its new value
                    if (r_dcnt[0]) begin
                        m_bg[r_k] <= sat40($signed({{10{r_bgd[39]}}, r_bgd})
                            + 50'(r_it.value));
                        r_st <= S_IDLE;
                    end else r_dcnt <= 6'd1;
                end
                S_EMIT1: begin
                    if (r_it.action == ACT_BWD) begin
                        r_o.kind <= KIND_IG; r_o.index <= r_it.row;
                        r_o.result <= sat16(48'(r_s >>> 8));
                        r_o.final_res <= 1'b1;
                        r_st <= S_OUT;
                    end else if (!r_ov) begin
                        // forward emit walk: read acc/bias for r_k
                        r_ov <= 1'b1; r_k <= '0; r_dcnt <= '0;
                    end else if (!r_dcnt[0]) r_dcnt <= 6'd1;
                    else begin
                        r_o.kind <= KIND_FWD; r_o.index <= r_k;
                        r_o.result <= sat16(48'(fsum >>> 8));
                        r_o.final_res <= lastk;
                        m_acc[r_k] <= '0;
                        r_st <= S_OUT;
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (!dtry[47]) r_rem <= dtry;
                    else r_rem <= {r_rem[46:0], r_q[47]};
                    r_q <= {r_q[46:0], ~dtry[47]};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd47) begin
                        r_o.index <= r_k; r_o.final_res <= lastk;
                        r_o.result <= (r_it.action == ACT_RD_WG) ? sat16(qs >>> 8)
                                                                 : sat16(qs);
                        r_st <= S_OUT;
                        if (r_it.action == ACT_RD_WG) r_o.kind <= KIND_WG;
                        else r_o.kind <= KIND_BG;
                    end
                end
                S_OUT: if (out_ch.ready) begin
                    r_dcnt <= '0;
                    if (r_o.final_res) begin r_st <= S_IDLE; r_ov <= 1'b0; end
                    else begin
                        r_k <= r_k + 6'd1;
                        r_st <= (r_it.action == ACT_FWD) ? S_EMIT1 : S_RD;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> !out_ch.valid) else $error("ready while output pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result dropped");
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_DIV |-> r_dcnt < 6'd48) else $error("divider overrun");
endmodule

// ----- test/tb.sv -----
// Self-checking testbench for dense_layer_forward_backward_core.
// Needs dlfb_pkg and dlfb_if from the RTL; predicts every result in fixed point.
`timescale 1ns / 1ps

module tb
    import dlfb_pkg::*;
();

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [10:0] i_cfg_data;

    dlfb_if #(.T(t_in))  in_ch ();
    dlfb_if #(.T(t_out)) out_ch ();

    dense_layer_forward_backward_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Layer model: stores, sums and the register copies as the core sees them
    longint wt_mem   [4096];
    longint bias_mem [64];
    longint acc_mem  [64];
    longint grad_mem [64];
    longint wg_sum   [4096];
    longint bg_sum   [64];
    bit     wt_set   [4096];
    bit     bias_set [64];
    bit     grad_set [64];
    int     reg_nin, reg_nout, reg_bias, reg_batch;

    t_out   layer_results_q[$];
    int     items_sent;
    int     results_seen;
    int     mismatches;
    int     burst_left;

    // Table of the directed stimulus; chk rows carry a typed result
    typedef struct {
        t_in              it;
        bit               chk;
        logic signed [15:0] ev;
    } t_row;

    function automatic int eff_nin();
        return reg_nin < 1 ? 1 : (reg_nin > 64 ? 64 : reg_nin);
    endfunction

    function automatic int eff_nout();
        return reg_nout < 1 ? 1 : (reg_nout > 64 ? 64 : reg_nout);
    endfunction

    function automatic longint sat(longint v, int bits);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic t_in mk(logic [2:0] a, int r, int c, logic [15:0] v, bit l);
        t_in it;
        it.action = a;
        it.row    = r[5:0];
        it.col    = c[5:0];
        it.value  = v;
        it.last   = l;
        return it;
    endfunction

    function automatic logic [15:0] rand_val();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_res(logic [1:0] kind, int idx, longint v, bit fin);
        t_out r;
        longint s;
        s = sat(v, 16);
        r.kind      = kind;
        r.index     = idx[5:0];
        r.result    = s[15:0];
        r.final_res = fin;
        layer_results_q = {layer_results_q, r};
    endtask

    // Work out the results of one transfer and advance the model state
    task automatic predict_layer(t_in it);
        int     row, col, nin, nout, batch, k;
        longint v, s, g;
        row   = it.row;
        col   = it.col;
        v     = longint'(it.value);
        nin   = eff_nin();
        nout  = eff_nout();
        batch = reg_batch < 1 ? 1 : (reg_batch > 1024 ? 1024 : reg_batch);
        case (it.action)
            ACT_LOAD_W: if (row < nin && col < nout) begin
                wt_mem[row * 64 + col] = v;
                wt_set[row * 64 + col] = 1'b1;
            end
            ACT_LOAD_B: if (col < nout) begin
                bias_mem[col] = v;
                bias_set[col] = 1'b1;
            end
            ACT_FWD: begin
                if (row < nin)
                    for (k = 0; k < nout; k++)
                        acc_mem[k] = sat(acc_mem[k] + wt_mem[row * 64 + k] * v, 40);
                if (it.last)
                    for (k = 0; k < nout; k++) begin
                        s = acc_mem[k];
                        if (reg_bias != 0)
                            s = sat(s + (bias_mem[k] <<< 8), 40);
                        push_res(KIND_FWD, k, s >>> 8, k == nout - 1);
                        acc_mem[k] = 0;
                    end
            end
            ACT_OGRAD: if (col < nout) begin
                grad_mem[col] = v;
                grad_set[col] = 1'b1;
                if (reg_bias != 0)
                    bg_sum[col] = sat(bg_sum[col] + v, 40);
            end
            ACT_BWD: if (row < nin) begin
                s = 0;
                for (k = 0; k < nout; k++) begin
                    g = grad_mem[k];
                    s = sat(s + wt_mem[row * 64 + k] * g, 40);
                    wg_sum[row * 64 + k] = sat(wg_sum[row * 64 + k] + v * g, 48);
                end
                push_res(KIND_IG, row, s >>> 8, 1'b1);
            end
            ACT_CLEAR: begin
                for (k = 0; k < 4096; k++) wg_sum[k] = 0;
                for (k = 0; k < 64; k++) bg_sum[k] = 0;
            end
            ACT_RD_WG: if (row < nin)
                for (k = 0; k < nout; k++)
                    push_res(KIND_WG, k, (wg_sum[row * 64 + k] / batch) >>> 8,
                             k == nout - 1);
            default:
                for (k = 0; k < nout; k++)
                    push_res(KIND_BG, k, bg_sum[k] / batch, k == nout - 1);
        endcase
    endtask

    // Offer one item in bursts with random gaps; record it once transferred
    task automatic put(t_in it, bit chk = 1'b0, logic signed [15:0] ev = '0);
        int gap, first, k;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        first = layer_results_q.size();
        predict_layer(it);
        if (chk)
            for (k = first; k < layer_results_q.size(); k++)
                layer_results_q[k].result = ev;
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Load whatever the next read of the stores would touch unwritten
    task automatic need_weights(int row);
        int k;
        for (k = 0; k < eff_nout(); k++)
            if (!wt_set[row * 64 + k]) put(mk(ACT_LOAD_W, row, k, rand_val(), 1'b0));
    endtask

    task automatic need_bias();
        int k;
        if (reg_bias != 0)
            for (k = 0; k < eff_nout(); k++)
                if (!bias_set[k]) put(mk(ACT_LOAD_B, 0, k, rand_val(), 1'b0));
    endtask

    task automatic need_grads();
        int k;
        for (k = 0; k < eff_nout(); k++)
            if (!grad_set[k]) put(mk(ACT_OGRAD, 0, k, rand_val(), 1'b0));
    endtask

    // Drain, let silent work (clear sweep, divider) finish, then write registers
    task automatic set_layer(int nin, int nout, int bias, int batch);
        in_ch.valid <= 1'b0;
        while (layer_results_q.size() != 0) @(negedge i_clk);
        repeat (5000) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_NIN;   i_cfg_data <= 11'(nin);   @(negedge i_clk);
        i_cfg_idx <= CFG_NOUT;  i_cfg_data <= 11'(nout);  @(negedge i_clk);
        i_cfg_idx <= CFG_BIAS;  i_cfg_data <= 11'(bias);  @(negedge i_clk);
        i_cfg_idx <= CFG_BATCH; i_cfg_data <= 11'(batch); @(negedge i_clk);
        i_cfg_we <= 1'b0;
        reg_nin   = nin & 127;
        reg_nout  = nout & 127;
        reg_bias  = bias & 1;
        reg_batch = batch & 2047;
        burst_left = 0;
    endtask

    // Mostly full training steps with random content, some noise on top
    task automatic run_random(int budget);
        int start, n, i, r, rows, row;
        t_in it;
        start = items_sent;
        while (items_sent - start < budget) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                rows = eff_nin() <= 8 ? eff_nin() : 3;
                for (i = 0; i < rows; i++) begin
                    row = eff_nin() <= 8 ? i : $urandom_range(0, eff_nin() - 1);
                    need_weights(row);
                    if (i == rows - 1) need_bias();
                    put(mk(ACT_FWD, row, $urandom, rand_val(), i == rows - 1));
                end
                for (i = 0; i < eff_nout(); i++)
                    put(mk(ACT_OGRAD, $urandom, i, rand_val(), 1'($urandom)));
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    row = $urandom_range(0, eff_nin() - 1);
                    need_weights(row);
                    put(mk(ACT_BWD, row, $urandom, rand_val(), 1'($urandom)));
                end
            end else if (r == 5) begin
                put(mk(ACT_RD_WG, $urandom_range(0, eff_nin() - 1), $urandom,
                       16'($urandom), 1'($urandom)));
            end else if (r == 6) begin
                put(mk(ACT_RD_BG, $urandom, $urandom, 16'($urandom), 1'($urandom)));
            end else if (r == 7 && $urandom_range(0, 2) == 0) begin
                put(mk(ACT_CLEAR, $urandom, $urandom, 16'($urandom), 1'($urandom)));
            end else begin
                // noise: any action, any indices, in range or not
                it = mk(3'($urandom), $urandom, $urandom, rand_val(), 1'($urandom));
                if (it.action == ACT_FWD && it.row < eff_nin()) need_weights(it.row);
                if (it.action == ACT_FWD && it.last) need_bias();
                if (it.action == ACT_BWD && it.row < eff_nin()) begin
                    need_weights(it.row);
                    need_grads();
                end
                put(it);
            end
        end
    endtask

    // Receiver: long stretches of steady ready, then random stalls
    int rx_cycle;
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[8])
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 9) < 6);
    end

    // Compare each transfer out with the oldest expectation
    always @(posedge i_clk) begin
        t_out e, a;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            a = out_ch.data;
            results_seen++;
            if (layer_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d index=%0d result=%0d final=%0b",
                             a.kind, a.index, a.result, a.final_res);
            end else begin
                e = layer_results_q.pop_front();
                if (a.kind !== e.kind || a.index !== e.index ||
                    a.result !== e.result || a.final_res !== e.final_res) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp kind=%0d index=%0d result=%0d final=%0b",
                                 e.kind, e.index, e.result, e.final_res);
                        $display("          got kind=%0d index=%0d result=%0d final=%0b",
                                 a.kind, a.index, a.result, a.final_res);
                    end
                end
            end
        end
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #50_000_000;
        $display("timeout with %0d results outstanding", layer_results_q.size());
        $display("FAIL");
        $finish;
    end

    t_row dir_tab[$];

    initial begin
        int i, k;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        rx_cycle     = 0;
        items_sent   = 0;
        results_seen = 0;
        mismatches   = 0;
        burst_left   = 0;
        reg_nin = 64; reg_nout = 64; reg_bias = 1; reg_batch = 1;
        for (k = 0; k < 4096; k++) begin
            wt_mem[k] = 0; wg_sum[k] = 0; wt_set[k] = 0;
        end
        for (k = 0; k < 64; k++) begin
            bias_mem[k] = 0; acc_mem[k] = 0; grad_mem[k] = 0; bg_sum[k] = 0;
            bias_set[k] = 0; grad_set[k] = 0;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Right after reset the gradient sums read back as zero
        put(mk(ACT_RD_WG, 63, 0, 16'h0, 1'b0), 1'b1, 16'sd0);
        put(mk(ACT_RD_BG, 0, 0, 16'h0, 1'b0), 1'b1, 16'sd0);

        // Tiny 2x2 layer with full-scale operands
        set_layer(2, 2, 1, 1);
        dir_tab = '{
            '{mk(ACT_LOAD_W, 0, 0, 16'h7fff, 0), 0, 0},
            '{mk(ACT_LOAD_W, 0, 1, 16'h8000, 0), 0, 0},
            '{mk(ACT_LOAD_W, 1, 0, 16'h0000, 0), 0, 0},
            '{mk(ACT_LOAD_W, 1, 1, 16'h0100, 0), 0, 0},
            '{mk(ACT_LOAD_W, 5, 0, 16'h1234, 0), 0, 0},   // row out of range: dropped
            '{mk(ACT_LOAD_B, 0, 0, 16'h7fff, 0), 0, 0},
            '{mk(ACT_LOAD_B, 0, 1, 16'h8000, 0), 0, 0},
            '{mk(ACT_LOAD_B, 0, 9, 16'h4321, 0), 0, 0},   // col out of range: dropped
            '{mk(ACT_FWD,    0, 0, 16'h7fff, 0), 0, 0},
            '{mk(ACT_FWD,    1, 0, 16'h8000, 1), 0, 0},
            '{mk(ACT_FWD,   40, 0, 16'h7fff, 1), 0, 0},   // out-of-range input, still emits
            '{mk(ACT_FWD,    0, 0, 16'h0100, 0), 0, 0},   // no last: silent
            '{mk(ACT_FWD,    1, 0, 16'hffff, 1), 0, 0},
            '{mk(ACT_OGRAD,  0, 0, 16'h8000, 0), 0, 0},
            '{mk(ACT_OGRAD,  0, 1, 16'h7fff, 0), 0, 0},
            '{mk(ACT_OGRAD,  0, 7, 16'h0100, 0), 0, 0},   // col out of range: dropped
            '{mk(ACT_BWD,    0, 0, 16'h7fff, 0), 0, 0},
            '{mk(ACT_BWD,    1, 0, 16'h8000, 0), 0, 0},
            '{mk(ACT_BWD,    3, 0, 16'h0100, 0), 0, 0},   // row out of range: dropped
            '{mk(ACT_RD_WG,  0, 0, 16'h0000, 0), 0, 0},
            '{mk(ACT_RD_WG,  2, 0, 16'h0000, 0), 0, 0},   // row out of range: nothing
            '{mk(ACT_RD_BG,  0, 0, 16'h0000, 0), 0, 0},
            '{mk(ACT_CLEAR,  0, 0, 16'h0000, 0), 0, 0},
            '{mk(ACT_RD_BG,  0, 0, 16'h0000, 0), 1, 0},
            '{mk(ACT_RD_WG,  1, 0, 16'h0000, 0), 1, 0}
        };
        for (i = 0; i < dir_tab.size(); i++)
            put(dir_tab[i].it, dir_tab[i].chk, dir_tab[i].ev);

        // Random phases, including zero and over-range register values
        set_layer(3, 5, 1, 3);       run_random(25);
        set_layer(1, 1, 0, 2047);    run_random(25);
        set_layer(0, 0, 1, 0);       run_random(25);
        set_layer(8, 3, 1, 1024);    run_random(30);
        set_layer(64, 4, 0, 7);      run_random(25);
        set_layer(127, 3, 1, 1);     run_random(15);

        // Over-range output count acts as the full width on the sum reads
        set_layer(127, 127, 1, 1);
        put(mk(ACT_RD_BG, 0, 0, 16'h0000, 1'b0));
        put(mk(ACT_RD_WG, 40, 0, 16'h0000, 1'b0));

        in_ch.valid <= 1'b0;
        while (layer_results_q.size() != 0) @(negedge i_clk);
        repeat (5000) @(negedge i_clk);

        $display("run covered %0d items over 9 register settings and %0d results",
                 items_sent, results_seen);
        $display("with %0d mismatches or stray results", mismatches);
        if (mismatches == 0 && layer_results_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/dlfb_pkg.sv
rtl/dlfb_if.sv
rtl/dense_layer_forward_backward_core.sv
test/tb.sv
